// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the regulator RTL files.
// Included by every module that carries concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)
`endif
`endif

// ===== hdl/ptfr_pkg.sv =====
// Shared widths, constants, register indexes and interface types of the regulator.
// Used by ptfr_div, pid_temperature_fan_regulator and the testbench; depends on nothing.
`default_nettype none

package ptfr_pkg;

    // Field and datapath widths.
    localparam int TEMP_W   = 12;
    localparam int ERR_W    = 13;
    localparam int DERR_W   = 14;
    localparam int TS_W     = 32;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 41;
    localparam int SUM_W    = 47;
    localparam int ACC_W    = 58;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 31;
    localparam int PROD_W   = 64;
    localparam int NUM_W    = 49;
    localparam int REM_W    = 32;
    localparam int CNT_W    = 6;
    localparam int FAN_W    = 8;
    localparam int CFG_W    = 41;
    localparam int IDX_W    = 3;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    // Integral is multiplied in two halves split at this bit.
    localparam int INTG_SPLIT = 24;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [IDX_W-1:0] REG_KP       = 3'd1;
    localparam logic [IDX_W-1:0] REG_KI       = 3'd2;
    localparam logic [IDX_W-1:0] REG_KD       = 3'd3;
    localparam logic [IDX_W-1:0] REG_UPPER    = 3'd4;
    localparam logic [IDX_W-1:0] REG_LOWER    = 3'd5;
    localparam logic [IDX_W-1:0] REG_ENABLE   = 3'd6;

    // Register reset values.
    localparam logic [TEMP_W-1:0] SETPOINT_RST = 12'd320;
    localparam logic [GAIN_W-1:0] KP_RST       = 16'd100;
    localparam logic [GAIN_W-1:0] KI_RST       = 16'd10;
    localparam logic [GAIN_W-1:0] KD_RST       = 16'd0;
    localparam logic [LIM_W-1:0]  UPPER_RST    = 41'd1600000;
    localparam logic [LIM_W-1:0]  LOWER_RST    = 41'h1FF_FFE7_9600;

    // Arithmetic constants.
    localparam logic [TS_W-1:0]  FIRST_DT     = 32'd100;
    localparam logic [MUL_A_W-1:0] KP_SCALE   = 33'd1000;
    localparam logic [MUL_A_W-1:0] KD_SCALE   = 33'd1000000;
    localparam logic [REM_W-1:0] OUT_DIVISOR  = 32'd1600000;
    localparam int   OUT_SHIFT    = 8;
    localparam logic [ACC_W-1:0] OUT_LIMIT    = 58'd409600000;
    localparam logic [FAN_W-1:0] FAN_MAX      = 8'hFF;

    // Divider iteration counts: derivative quotient and final scaling.
    localparam logic [CNT_W-1:0] ITERS_DERIV  = 6'd49;
    localparam logic [CNT_W-1:0] ITERS_OUT    = 6'd8;

    // Divider request and status.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ptfr_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for the regulator.
// Depends on ptfr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ptfr_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ptfr_pkg::div_ctl_t          ctl,
    input  wire logic [ptfr_pkg::NUM_W-1:0]  dividend,
    input  wire logic [ptfr_pkg::REM_W-1:0]  rem_init,
    input  wire logic [ptfr_pkg::REM_W-1:0]  divisor,
    output ptfr_pkg::div_sts_t               sts,
    output logic      [ptfr_pkg::NUM_W-1:0]  quotient,
    output logic      [ptfr_pkg::REM_W-1:0]  remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ptfr_pkg::CNT_W-1:0]    cnt_reg;
    logic [ptfr_pkg::NUM_W-1:0]    dq_reg;
    logic [ptfr_pkg::NUM_W-1:0]    dq_next;
    logic [ptfr_pkg::REM_W-1:0]    rem_reg;
    logic [ptfr_pkg::REM_W-1:0]    rem_next;
    logic [ptfr_pkg::REM_W-1:0]    dvs_reg;
    logic [ptfr_pkg::REM_W:0]      trial;
    logic [ptfr_pkg::REM_W:0]      diff;
    logic                          ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[ptfr_pkg::NUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[ptfr_pkg::REM_W-1:0] : trial[ptfr_pkg::REM_W-1:0];
        dq_next  = {dq_reg[ptfr_pkg::NUM_W-2:0], ge};
    end

    // Iteration control; done pulses for one cycle after the last step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctl.iters;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ptfr_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dq_reg  <= dividend;
            rem_reg <= rem_init;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

    `ASSERT_CLK(a_start_when_free, clk, rst_n, ctl.start |-> !busy_reg, "divider started while busy")
    `ASSERT_CLK(a_count_live, clk, rst_n, busy_reg |-> (cnt_reg != '0), "divider busy with zero count")
    `ASSERT_CLK(a_rem_below, clk, rst_n, busy_reg |-> (rem_reg < dvs_reg), "partial remainder not below divisor")
    `ASSERT_CLK(a_done_after_busy, clk, rst_n, done_reg |-> $past(busy_reg), "done without a running division")

endmodule

`default_nettype wire

// ===== hdl/pid_temperature_fan_regulator.sv =====
// PID fan regulator: one enabled sample in, one fan duty out, with integral clamping.
// Depends on ptfr_pkg, ptfr_div and assert_macros.svh.
//
// Each accepted sample carries a temperature and a millisecond timestamp. While
// enabled, the block computes the PID sum with one shared 33x31 multiplier and
// a one-bit-per-cycle serial divider, and returns one fan duty 0..255. The final
// scaling divide is skipped when the sum lies outside the fan range; the 49
// iterations of the derivative divide dominate the work. The input is not ready
// while a sample is being worked on and becomes ready again as the duty is
// registered, so a new sample waits until the last one is through; a duty that
// waits on the output stalls the next sample once that one is finished. A sample
// accepted while disabled is taken without leaving idle, gives no result and
// leaves the state untouched. Configuration is to be written only while no
// sample is in progress; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module pid_temperature_fan_regulator
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration write port.
    input  wire logic                           wr_en,
    input  wire logic [ptfr_pkg::IDX_W-1:0]     wr_index,
    input  wire logic [ptfr_pkg::CFG_W-1:0]     wr_data,
    // Sample input.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] temperature, [43:12] timestamp_ms, [47:44] zero
    input  wire logic [ptfr_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // Fan duty output.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] fan_speed
    output logic      [ptfr_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P1     = 4'd1;
    localparam logic [3:0] S_INT    = 4'd2;
    localparam logic [3:0] S_CLAMP  = 4'd3;
    localparam logic [3:0] S_KP     = 4'd4;
    localparam logic [3:0] S_KILO   = 4'd5;
    localparam logic [3:0] S_KIHI   = 4'd6;
    localparam logic [3:0] S_KD     = 4'd7;
    localparam logic [3:0] S_DSTART = 4'd8;
    localparam logic [3:0] S_DWAIT  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_FWAIT  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam int TEMP_W  = ptfr_pkg::TEMP_W;
    localparam int ERR_W   = ptfr_pkg::ERR_W;
    localparam int DERR_W  = ptfr_pkg::DERR_W;
    localparam int TS_W    = ptfr_pkg::TS_W;
    localparam int GAIN_W  = ptfr_pkg::GAIN_W;
    localparam int LIM_W   = ptfr_pkg::LIM_W;
    localparam int SUM_W   = ptfr_pkg::SUM_W;
    localparam int ACC_W   = ptfr_pkg::ACC_W;
    localparam int MUL_A_W = ptfr_pkg::MUL_A_W;
    localparam int MUL_B_W = ptfr_pkg::MUL_B_W;
    localparam int PROD_W  = ptfr_pkg::PROD_W;
    localparam int NUM_W   = ptfr_pkg::NUM_W;
    localparam int REM_W   = ptfr_pkg::REM_W;
    localparam int FAN_W   = ptfr_pkg::FAN_W;
    localparam int SPLIT   = ptfr_pkg::INTG_SPLIT;
    localparam int OSHIFT  = ptfr_pkg::OUT_SHIFT;

    // Configuration registers.
    logic [TEMP_W-1:0] setpoint_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kd_reg;
    logic [LIM_W-1:0]  upper_reg;
    logic [LIM_W-1:0]  lower_reg;
    logic              enable_reg;

    // Regulator state.
    logic [LIM_W-1:0]  intg_reg;
    logic [ERR_W-1:0]  prev_err_reg;
    logic [TS_W-1:0]   prev_time_reg;
    logic              first_reg;

    // Sequencer and working registers.
    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [ERR_W-1:0]  err_reg;
    logic [DERR_W-1:0] derr_reg;
    logic [TS_W-1:0]   dt_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] mul_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              neg_reg;
    logic [FAN_W-1:0]  res_reg;
    logic              out_valid_reg;
    logic [FAN_W-1:0]  out_data_reg;

    logic                     s_fire;
    logic                     out_load;
    logic [TEMP_W-1:0]        in_temp;
    logic [TS_W-1:0]          in_ts;
    logic [TS_W-1:0]          dt_raw;
    logic [TS_W-1:0]          dt_new;
    logic [ERR_W-1:0]         err_new;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_mag;
    logic [ACC_W-1:0]         dmag;
    logic                     out_in_range;
    logic [LIM_W-1:0]         intg_clamped;

    ptfr_pkg::div_ctl_t       div_ctl;
    ptfr_pkg::div_sts_t       div_sts;
    logic [NUM_W-1:0]         div_dividend;
    logic [REM_W-1:0]         div_rem_init;
    logic [REM_W-1:0]         div_divisor;
    logic [NUM_W-1:0]         div_quot;
    logic [REM_W-1:0]         div_rem;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_temp       = s_axis_tdata[TEMP_W-1:0];
    assign in_ts         = s_axis_tdata[TEMP_W+TS_W-1:TEMP_W];

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= ptfr_pkg::SETPOINT_RST;
            kp_reg       <= ptfr_pkg::KP_RST;
            ki_reg       <= ptfr_pkg::KI_RST;
            kd_reg       <= ptfr_pkg::KD_RST;
            upper_reg    <= ptfr_pkg::UPPER_RST;
            lower_reg    <= ptfr_pkg::LOWER_RST;
            enable_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ptfr_pkg::REG_SETPOINT: setpoint_reg <= wr_data[TEMP_W-1:0];
                ptfr_pkg::REG_KP:       kp_reg       <= wr_data[GAIN_W-1:0];
                ptfr_pkg::REG_KI:       ki_reg       <= wr_data[GAIN_W-1:0];
                ptfr_pkg::REG_KD:       kd_reg       <= wr_data[GAIN_W-1:0];
                ptfr_pkg::REG_UPPER:    upper_reg    <= wr_data[LIM_W-1:0];
                ptfr_pkg::REG_LOWER:    lower_reg    <= wr_data[LIM_W-1:0];
                ptfr_pkg::REG_ENABLE:   enable_reg   <= wr_data[0];
                default:                ;
            endcase
        end
    end

    // Error and time step of a new sample; a zero step counts as one millisecond.
    always_comb
    begin
        err_new = {setpoint_reg[TEMP_W-1], setpoint_reg} - {in_temp[TEMP_W-1], in_temp};
        dt_raw  = first_reg ? ptfr_pkg::FIRST_DT : (in_ts - prev_time_reg);
        dt_new  = (dt_raw == '0) ? TS_W'(1) : dt_raw;
    end

    // Integral clamp: the upper limit is tested first.
    always_comb
    begin
        if ($signed(sum_reg) > $signed({{(SUM_W-LIM_W){upper_reg[LIM_W-1]}}, upper_reg}))
        begin
            intg_clamped = upper_reg;
        end
        else if ($signed(sum_reg) < $signed({{(SUM_W-LIM_W){lower_reg[LIM_W-1]}}, lower_reg}))
        begin
            intg_clamped = lower_reg;
        end
        else
        begin
            intg_clamped = sum_reg[LIM_W-1:0];
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            S_P1:
            begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = $signed({{(MUL_B_W-ERR_W){err_reg[ERR_W-1]}}, err_reg});
            end
            S_INT:
            begin
                mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, kp_reg});
                mul_b = $signed({{(MUL_B_W-ERR_W){err_reg[ERR_W-1]}}, err_reg});
            end
            S_CLAMP:
            begin
                mul_a = $signed(ptfr_pkg::KP_SCALE);
                mul_b = $signed(mul_reg[MUL_B_W-1:0]);
            end
            S_KP:
            begin
                mul_a = $signed({{(MUL_A_W-SPLIT){1'b0}}, intg_reg[SPLIT-1:0]});
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, ki_reg});
            end
            S_KILO:
            begin
                mul_a = $signed({{(MUL_A_W-LIM_W+SPLIT){intg_reg[LIM_W-1]}},
                                 intg_reg[LIM_W-1:SPLIT]});
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, ki_reg});
            end
            S_KIHI:
            begin
                mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, kd_reg});
                mul_b = $signed({{(MUL_B_W-DERR_W){derr_reg[DERR_W-1]}}, derr_reg});
            end
            S_KD:
            begin
                mul_a = $signed(ptfr_pkg::KD_SCALE);
                mul_b = $signed(mul_reg[MUL_B_W-1:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_mag = mul_reg[PROD_W-1] ? $unsigned(-$signed(mul_reg)) : mul_reg;

    // Floor of the derivative quotient: a negative quotient with a remainder
    // moves one further away from zero.
    assign dmag = {{(ACC_W-NUM_W){1'b0}}, div_quot} + ACC_W'(neg_reg && (div_rem != '0));

    // The final scaling divide runs only when the quotient lands in 0..255.
    assign out_in_range = !acc_reg[ACC_W-1] && (acc_reg < ptfr_pkg::OUT_LIMIT);

    // Divider requests.
    always_comb
    begin
        div_ctl      = '0;
        div_dividend = '0;
        div_rem_init = '0;
        div_divisor  = '0;
        case (state_reg)
            S_DSTART:
            begin
                div_ctl.start = 1'b1;
                div_ctl.iters = ptfr_pkg::ITERS_DERIV;
                div_dividend  = prod_mag[NUM_W-1:0];
                div_divisor   = dt_reg;
            end
            S_FIN:
            begin
                div_ctl.start = out_in_range;
                div_ctl.iters = ptfr_pkg::ITERS_OUT;
                div_dividend  = {acc_reg[OSHIFT-1:0], {(NUM_W-OSHIFT){1'b0}}};
                div_rem_init  = {{(REM_W-29+OSHIFT){1'b0}}, acc_reg[28:OSHIFT]};
                div_divisor   = ptfr_pkg::OUT_DIVISOR;
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    ptfr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .rem_init  (div_rem_init),
        .divisor   (div_divisor),
        .sts       (div_sts),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_fire && enable_reg) state_next = S_P1;
            S_P1:     state_next = S_INT;
            S_INT:    state_next = S_CLAMP;
            S_CLAMP:  state_next = S_KP;
            S_KP:     state_next = S_KILO;
            S_KILO:   state_next = S_KIHI;
            S_KIHI:   state_next = S_KD;
            S_KD:     state_next = S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:  if (div_sts.done) state_next = S_FIN;
            S_FIN:    state_next = out_in_range ? S_FWAIT : S_OUT;
            S_FWAIT:  if (div_sts.done) state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state and regulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            intg_reg      <= '0;
            prev_err_reg  <= '0;
            prev_time_reg <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && s_fire && enable_reg)
            begin
                prev_time_reg <= in_ts;
                first_reg     <= 1'b0;
            end
            if (state_reg == S_P1)
            begin
                prev_err_reg <= err_reg;
            end
            if (state_reg == S_CLAMP)
            begin
                intg_reg <= intg_clamped;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working datapath registers.
    always_ff @(posedge clk)
    begin
        mul_reg <= $unsigned(prod);
        case (state_reg)
            S_IDLE:
            begin
                err_reg <= err_new;
                dt_reg  <= dt_new;
            end
            S_P1:
            begin
                derr_reg <= {err_reg[ERR_W-1], err_reg}
                          - {prev_err_reg[ERR_W-1], prev_err_reg};
            end
            S_INT:
            begin
                sum_reg <= {{(SUM_W-LIM_W){intg_reg[LIM_W-1]}}, intg_reg}
                         + mul_reg[SUM_W-1:0];
            end
            S_KP:
            begin
                acc_reg <= mul_reg[ACC_W-1:0];
            end
            S_KILO:
            begin
                acc_reg <= acc_reg + mul_reg[ACC_W-1:0];
            end
            S_KIHI:
            begin
                acc_reg <= acc_reg + {mul_reg[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}};
            end
            S_DSTART:
            begin
                neg_reg <= mul_reg[PROD_W-1];
            end
            S_DWAIT:
            begin
                if (div_sts.done)
                begin
                    acc_reg <= neg_reg ? (acc_reg - dmag) : (acc_reg + dmag);
                end
            end
            S_FIN:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    res_reg <= '0;
                end
                else if (!out_in_range)
                begin
                    res_reg <= ptfr_pkg::FAN_MAX;
                end
            end
            S_FWAIT:
            begin
                if (div_sts.done)
                begin
                    res_reg <= div_quot[FAN_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ASSERT_NEVER(a_done_in_wait, clk, rst_n, div_sts.done && !(state_reg == S_DWAIT || state_reg == S_FWAIT), "divider result outside a wait state")
    `ASSERT_CLK(a_disabled_drop, clk, rst_n, (s_fire && !enable_reg) |=> (state_reg == S_IDLE), "disabled sample started work")
    `ASSERT_CLK(a_first_clear, clk, rst_n, $fell(first_reg) |-> $past(s_fire && enable_reg), "first-sample flag cleared without a sample")
    `ASSERT_CLK(a_dt_nonzero, clk, rst_n, (state_reg == S_P1) |-> (dt_reg != '0), "zero time step reached the datapath")

endmodule

`default_nettype wire

// ===== test/pid_temperature_fan_regulator_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pid_temperature_fan_regulator: stream samples in, fan duties out.
// Depends on ptfr_pkg and the regulator RTL; predicts every duty and compares it on arrival.

module pid_temperature_fan_regulator_test;

    localparam int     IDX_W         = ptfr_pkg::IDX_W;
    localparam int     CFG_W         = ptfr_pkg::CFG_W;
    localparam int     S_DATA_W      = ptfr_pkg::S_DATA_W;
    localparam int     M_DATA_W      = ptfr_pkg::M_DATA_W;
    localparam int     TEMP_W        = ptfr_pkg::TEMP_W;
    localparam int     TS_W          = ptfr_pkg::TS_W;
    localparam int     GAIN_W        = ptfr_pkg::GAIN_W;
    localparam int     LIM_W         = ptfr_pkg::LIM_W;
    localparam int     FAN_W         = ptfr_pkg::FAN_W;

    localparam int     HALF_PERIOD   = 2;
    localparam int     RESET_CYCLES  = 9;
    localparam int     MAX_IDLE      = 14;
    localparam int     SETTLE_CYCLES = 120;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_ITEMS   = 150;
    localparam longint TIMEOUT_NS    = 4000000;
    localparam longint FIRST_STEP_MS = 100;
    localparam longint OUT_DEN       = 1600000;
    localparam longint GAIN_MAX      = 65535;
    localparam longint LIMIT_MAX     = (64'sd1 <<< 40) - 1;
    localparam longint LIMIT_MIN     = -(64'sd1 <<< 40);
    localparam longint TEMP_MAX      = 2047;
    localparam longint TEMP_MIN      = -2048;
    localparam longint DUTY_MAX      = 255;

    // Register slot past the last defined one; writes to it must be ignored.
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 wr_en         = 1'b0;
    logic [IDX_W-1:0]     wr_index      = '0;
    logic [CFG_W-1:0]     wr_data       = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;

    // Predicted configuration and regulator state.
    longint               cfg_setpoint;
    longint               cfg_kp;
    longint               cfg_ki;
    longint               cfg_kd;
    longint               cfg_upper;
    longint               cfg_lower;
    bit                   cfg_enable;
    longint               pid_integral;
    longint               pid_prev_err;
    logic [TS_W-1:0]      pid_prev_ts;
    bit                   pid_first;

    // Fan duties still owed by the block, oldest first.
    logic [FAN_W-1:0]     fan_expected[$];
    logic [FAN_W-1:0]     duty_want;

    bit                   idle_on       = 1'b1;
    int                   hold_trigger  = 0;
    int                   hold_seen     = 0;
    int                   hold_left     = 0;
    int                   rx_stall      = 0;
    int                   items_sent    = 0;
    int                   results_checked = 0;
    int                   mismatch_count  = 0;
    int                   config_loads    = 0;
    logic [TS_W-1:0]      last_stamp    = '0;

    pid_temperature_fan_regulator DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Run limit in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Run limit reached with %0d fan duties outstanding.", fan_expected.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    // Long output hold-off, counted here once it is triggered.
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Output ready: random stalls after each transfer while idling is on, held low during a hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end
        else if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready)
        begin
            rx_stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            m_axis_tready <= (rx_stall == 0);
        end
        else if (rx_stall != 0)
        begin
            rx_stall--;
            m_axis_tready <= (rx_stall == 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compares each fan duty transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (fan_expected.size() == 0)
                report_mismatch($sformatf("fan duty %0d with none predicted", m_axis_tdata));
            else
            begin
                duty_want = fan_expected.pop_front();
                if (m_axis_tdata !== duty_want)
                    report_mismatch($sformatf("fan_speed %0d, predicted %0d",
                                              m_axis_tdata, duty_want));
                results_checked++;
            end
        end
    end

    function automatic void reset_predictor();
        cfg_setpoint = 320;
        cfg_kp       = 100;
        cfg_ki       = 10;
        cfg_kd       = 0;
        cfg_upper    = 1600000;
        cfg_lower    = -1600000;
        cfg_enable   = 1'b0;
        pid_integral = 0;
        pid_prev_err = 0;
        pid_prev_ts  = '0;
        pid_first    = 1'b1;
    endfunction

    // Mirrors one register write into the predicted configuration.
    function automatic void note_reg_write(input logic [IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
        logic signed [TEMP_W-1:0] sp;
        logic signed [LIM_W-1:0]  lim;
        sp  = data[TEMP_W-1:0];
        lim = data[LIM_W-1:0];
        case (idx)
            ptfr_pkg::REG_SETPOINT: cfg_setpoint = sp;
            ptfr_pkg::REG_KP:       cfg_kp       = data[GAIN_W-1:0];
            ptfr_pkg::REG_KI:       cfg_ki       = data[GAIN_W-1:0];
            ptfr_pkg::REG_KD:       cfg_kd       = data[GAIN_W-1:0];
            ptfr_pkg::REG_UPPER:    cfg_upper    = lim;
            ptfr_pkg::REG_LOWER:    cfg_lower    = lim;
            ptfr_pkg::REG_ENABLE:   cfg_enable   = data[0];
            default:                ;
        endcase
    endfunction

    // Division rounded toward minus infinity, for a positive divisor.
    function automatic longint floor_quot(input longint num, input longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Advances the regulator state by one sample; returns 1 when a duty comes out.
    function automatic bit predict_fan_duty(input logic [TEMP_W-1:0] temp_bits,
                                            input logic [TS_W-1:0] stamp,
                                            output logic [FAN_W-1:0] duty);
        logic signed [TEMP_W-1:0] temp_s;
        logic [TS_W-1:0]          step_ms;
        longint                   step;
        longint                   err;
        longint                   derr;
        longint                   acc;
        longint                   res;
        duty = '0;
        if (!cfg_enable)
            return 1'b0;
        temp_s = temp_bits;

        // Time step: fixed on the first sample, wrapped difference after that.
        if (pid_first)
        begin
            pid_first = 1'b0;
            step_ms   = TS_W'(FIRST_STEP_MS);
        end
        else
            step_ms = stamp - pid_prev_ts;
        pid_prev_ts = stamp;
        if (step_ms == '0)
            step_ms = TS_W'(1);
        step = step_ms;

        err = cfg_setpoint - temp_s;

        // Integral with clamping; the upper limit is tested first.
        pid_integral += err * step;
        if (pid_integral > cfg_upper)
            pid_integral = cfg_upper;
        else if (pid_integral < cfg_lower)
            pid_integral = cfg_lower;

        derr = err - pid_prev_err;
        pid_prev_err = err;

        acc = cfg_kp * err * 1000 + cfg_ki * pid_integral
            + floor_quot(cfg_kd * derr * 1000000, step);
        res = floor_quot(acc, OUT_DEN);
        if (res < 0)
            res = 0;
        if (res > DUTY_MAX)
            res = DUTY_MAX;
        duty = res[FAN_W-1:0];
        return 1'b1;
    endfunction

    // Sends one sample, after a random gap when idling is on, and records its predicted duty.
    task automatic send_sample(input logic [TEMP_W-1:0] temp, input logic [TS_W-1:0] stamp);
        int               gap;
        logic [FAN_W-1:0] duty;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - TEMP_W - TS_W){1'b0}}, stamp, temp};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (predict_fan_duty(temp, stamp, duty))
            fan_expected.push_back(duty);
        items_sent++;
        last_stamp = stamp;
    endtask

    // Stops the sender, waits for every duty, then lets the block go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (fan_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        note_reg_write(idx, data);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input longint sp, input longint kp, input longint ki,
                               input longint kd, input longint up, input longint lo,
                               input bit en);
        write_reg(ptfr_pkg::REG_SETPOINT, sp[CFG_W-1:0]);
        write_reg(ptfr_pkg::REG_KP,       kp[CFG_W-1:0]);
        write_reg(ptfr_pkg::REG_KI,       ki[CFG_W-1:0]);
        write_reg(ptfr_pkg::REG_KD,       kd[CFG_W-1:0]);
        write_reg(ptfr_pkg::REG_UPPER,    up[CFG_W-1:0]);
        write_reg(ptfr_pkg::REG_LOWER,    lo[CFG_W-1:0]);
        write_reg(ptfr_pkg::REG_ENABLE,   {{(CFG_W-1){1'b0}}, en});
        config_loads++;
    endtask

    // Mostly plausible steps forward, with repeats, backward jumps and wild values.
    function automatic logic [TS_W-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return last_stamp + $urandom_range(1, 250);
        else if (pick < 78)
            return last_stamp;
        else if (pick < 86)
            return last_stamp - $urandom_range(1, 500);
        return $urandom;
    endfunction

    // Mostly near the setpoint so the duty lands inside its range, else anywhere.
    function automatic logic [TEMP_W-1:0] random_temp();
        int     off;
        longint t;
        if ($urandom_range(0, 9) < 6)
        begin
            off = $urandom_range(0, 400);
            off -= 200;
            t = cfg_setpoint + off;
            if (t > TEMP_MAX)
                t = TEMP_MAX;
            if (t < TEMP_MIN)
                t = TEMP_MIN;
            return t[TEMP_W-1:0];
        end
        return TEMP_W'($urandom_range(0, 4095));
    endfunction

    function automatic longint random_setpoint();
        longint sp;
        sp = $urandom_range(0, 4095);
        return sp + TEMP_MIN;
    endfunction

    // Picks a configuration: the first phases take the extremes, later ones vary.
    task automatic load_random_config(input int phase);
        int     kind;
        longint up;
        longint lo;
        kind = (phase < 3) ? phase : $urandom_range(3, 8);
        case (kind)
            0: load_config(TEMP_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX, LIMIT_MIN, 1'b1);
            1: load_config(TEMP_MIN, 0, 0, 0, 0, 0, 1'b1);
            2: load_config(random_setpoint(), $urandom_range(100, 300), 0,
                           $urandom_range(0, 100), LIMIT_MIN, LIMIT_MAX, 1'b1);
            6:
            begin
                // Crossed limits with live integral gain.
                up = $urandom_range(0, 1000000);
                lo = $urandom_range(0, 1000000);
                load_config(random_setpoint(), $urandom_range(0, 300), $urandom_range(0, 200),
                            $urandom_range(0, 100), -up, lo, 1'b1);
            end
            7: load_config(random_setpoint(), $urandom_range(0, GAIN_MAX),
                           $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                           $urandom_range(0, 200000000), -longint'($urandom_range(0, 200000000)),
                           1'b1);
            8: load_config(random_setpoint(), $urandom_range(50, 300), $urandom_range(0, 3000),
                           $urandom_range(0, 200), $urandom_range(0, 20000),
                           -longint'($urandom_range(0, 20000)), 1'b1);
            default:
            begin
                up = $urandom_range(0, 200000000);
                lo = $urandom_range(0, 200000000);
                load_config(random_setpoint(), $urandom_range(0, 400), $urandom_range(0, 2000),
                            $urandom_range(0, 200), up, -lo, 1'b1);
            end
        endcase
    endtask

    // Reset values with regulation on: first sample, repeated and wrapping timestamps.
    task automatic test_first_samples();
        write_reg(ptfr_pkg::REG_ENABLE, {{(CFG_W-1){1'b0}}, 1'b1});
        send_sample(12'd0, 32'd5000);
        send_sample(12'd0, 32'd5000);
        send_sample(12'h7FF, 32'd5100);
        send_sample(12'h800, 32'd5200);
        send_sample(12'd320, 32'hFFFF_FFFF);
        send_sample(12'd100, 32'd3);
        send_sample(12'h800, 32'd0);
        send_sample(12'h7FF, 32'd0);
    endtask

    // Disabled samples must leave the state alone; the spare register index is ignored.
    task automatic test_disabled_hold();
        settle();
        write_reg(ptfr_pkg::REG_ENABLE, '0);
        send_sample(12'h123, 32'd900);
        send_sample(12'h7FF, 32'hFFFF_0000);
        send_sample(12'h800, 32'd77);
        send_sample(12'hABC, 32'h8000_0001);
        settle();
        write_reg(REG_SPARE, {CFG_W{1'b1}});
        write_reg(ptfr_pkg::REG_ENABLE, {{(CFG_W-1){1'b0}}, 1'b1});
        send_sample(12'd300, 32'd60);
        send_sample(12'd340, 32'd160);
    endtask

    // Crossed integral limits, negative sums and full-scale gains.
    task automatic test_limits_and_clamps();
        settle();
        load_config(0, 100, 1000, 0, -1000, 1000, 1'b1);
        send_sample(-12'sd500, 32'd1000);
        send_sample(12'd500, 32'd1100);
        send_sample(12'h7FF, 32'd1200);
        settle();
        load_config(TEMP_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX, LIMIT_MIN, 1'b1);
        send_sample(12'h800, 32'd1201);
        send_sample(12'h7FF, 32'd1202);
        send_sample(12'h7FF, 32'd1202);
    endtask

    // Random samples over a series of configurations, some phases without idling.
    task automatic test_random_regulation();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            idle_on = (phase % 4) != 3;
            load_random_config(phase);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(random_temp(), next_stamp());
        end
    endtask

    // The output is held off for a long stretch while samples keep coming.
    task automatic test_output_backpressure();
        settle();
        idle_on = 1'b0;
        load_config(320, 150, 200, 50, 2000000, -2000000, 1'b1);
        hold_trigger <= hold_trigger + 1;
        for (int k = 0; k < 25; k++)
            send_sample(random_temp(), next_stamp());
    endtask

    // The sender pauses until every duty has arrived, then carries on.
    task automatic test_sender_pause();
        settle();
        idle_on = 1'b1;
        load_random_config(3);
        for (int k = 0; k < 40; k++)
            send_sample(random_temp(), next_stamp());
        s_axis_tvalid <= 1'b0;
        while (fan_expected.size() != 0)
            @(posedge clk);
        for (int k = 0; k < 40; k++)
            send_sample(random_temp(), next_stamp());
    endtask

    initial
    begin
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_samples();
        test_disabled_hold();
        test_limits_and_clamps();
        test_random_regulation();
        test_output_backpressure();
        test_sender_pause();

        // Drain with a bound, then give the block time to show stray transfers.
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && fan_expected.size() != 0; n++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fan_expected.size() != 0)
            report_mismatch($sformatf("%0d fan duties never arrived", fan_expected.size()));

        $display("Sent %0d samples over %0d configurations; %0d fan duties compared.",
                 items_sent, config_loads, results_checked);
        $display("Included disabled samples, crossed limits, timestamp wrap and output hold-off.");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ptfr_pkg.sv
hdl/ptfr_div.sv
hdl/pid_temperature_fan_regulator.sv
test/pid_temperature_fan_regulator_test.sv
